FILE: rtl/u16u8_pkg.sv
// Shared types and UTF-8 encoding helpers for the UTF-16LE to UTF-8 transcoder.
// No dependencies; used by the front end, the command queue and the byte emitter.
package u16u8_pkg;

    localparam int CP_W = 21;
    localparam logic [CP_W-1:0] CP_REPL  = 21'h00FFFD;
    localparam logic [CP_W-1:0] CP_SUPP  = 21'h010000;
    localparam logic [5:0]      HI_TAG   = 6'b110110;   // 0xD800..0xDBFF
    localparam logic [5:0]      LO_TAG   = 6'b110111;   // 0xDC00..0xDFFF
    localparam logic [7:0]      LEAD2    = 8'hC0;
    localparam logic [7:0]      LEAD3    = 8'hE0;
    localparam logic [7:0]      LEAD4    = 8'hF0;
    localparam logic [7:0]      CONT     = 8'h80;

    // One decoded unit: optional U+FFFD prefix, optional code point, optional NUL.
    typedef struct packed {
        logic            pre;
        logic            has_cp;
        logic [CP_W-1:0] cp;
        logic            term;
    } t_cmd;

    typedef enum logic [2:0] {
        PH_PRE  = 3'b001,
        PH_CP   = 3'b010,
        PH_TERM = 3'b100
    } t_phase;

    // Index of the last byte of the encoding (byte count minus one).
    function automatic logic [1:0] utf8_last(input logic [CP_W-1:0] cp);
        logic [1:0] r;
        if (cp[CP_W-1:7] == '0) begin
            r = 2'd0;
        end else if (cp[CP_W-1:11] == '0) begin
            r = 2'd1;
        end else if (cp[CP_W-1:16] == '0) begin
            r = 2'd2;
        end else begin
            r = 2'd3;
        end
        return r;
    endfunction

    function automatic logic [7:0] utf8_byte(input logic [CP_W-1:0] cp,
                                             input logic [1:0] idx);
        logic [7:0] b [4];
        logic [1:0] last;
        last = utf8_last(cp);
        b[0] = '0;
        b[1] = '0;
        b[2] = '0;
        b[3] = '0;
        case (last)
            2'd0: begin
                b[0] = {1'b0, cp[6:0]};
            end
            2'd1: begin
                b[0] = LEAD2 | {3'b000, cp[10:6]};
                b[1] = CONT  | {2'b00, cp[5:0]};
            end
            2'd2: begin
                b[0] = LEAD3 | {4'b0000, cp[15:12]};
                b[1] = CONT  | {2'b00, cp[11:6]};
                b[2] = CONT  | {2'b00, cp[5:0]};
            end
            default: begin
                b[0] = LEAD4 | {5'b00000, cp[20:18]};
                b[1] = CONT  | {2'b00, cp[17:12]};
                b[2] = CONT  | {2'b00, cp[11:6]};
                b[3] = CONT  | {2'b00, cp[5:0]};
            end
        endcase
        return b[idx];
    endfunction

    function automatic t_phase first_phase(input t_cmd c);
        t_phase p;
        if (c.pre) begin
            p = PH_PRE;
        end else if (c.has_cp) begin
            p = PH_CP;
        end else begin
            p = PH_TERM;
        end
        return p;
    endfunction

endpackage

FILE: rtl/u16u8_ifc.sv
// Valid/ready channel interfaces for the transcoder: UTF-16 units in, UTF-8 bytes out.
// No dependencies.
interface u16u8_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] code_unit;
    logic        buffer_end;

    modport source (output valid, output code_unit, output buffer_end, input ready);
    modport sink   (input valid, input code_unit, input buffer_end, output ready);
endinterface

interface u16u8_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       string_done;

    modport source (output valid, output out_byte, output string_done, input ready);
    modport sink   (input valid, input out_byte, input string_done, output ready);
endinterface

FILE: rtl/utf16le_to_utf8_transcoder_top.sv
// UTF-16LE to UTF-8 transcoder.
// Input channel i_in: one UTF-16 code unit per transfer plus buffer_end on the
// last unit of a buffer. Output channel o_out: one UTF-8 byte per transfer;
// string_done marks the NUL that ends a string (on a zero unit or buffer end).
// Ill-formed surrogates come out as U+FFFD (EF BF BD).
// A unit passes the queue and the emitter's command and output registers.
// Throughput: the byte emitter sends one byte per cycle unless o_out stalls;
// a unit yields 1 to 3 bytes for a BMP character, 4 for a surrogate pair,
// 0 for a held high surrogate, up to 7 for the longest case.
// The front end keeps accepting units while the queue has room.
// Reset clears the pending surrogate, the queue and the output valid flag.
// A stall on o_out holds the output byte; the emitter and then the queue
// fill, and only then does i_in.ready drop.
// Depends on u16u8_pkg, u16u8_ifc, u16u8_front, u16u8_queue, u16u8_back.
module utf16le_to_utf8_transcoder_top #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    u16u8_in_if.sink     i_in,
    u16u8_out_if.source  o_out
);

    logic            f_valid;
    logic            q_ready;
    logic            q_valid;
    logic            q_pop;
    u16u8_pkg::t_cmd f_cmd;
    u16u8_pkg::t_cmd q_cmd;

    u16u8_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_cmd_valid (f_valid),
        .o_cmd       (f_cmd),
        .i_cmd_ready (q_ready)
    );

    u16u8_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_valid),
        .i_data  (f_cmd),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_data  (q_cmd),
        .i_pop   (q_pop)
    );

    u16u8_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_cmd),
        .o_cmd_pop   (q_pop),
        .o_out       (o_out)
    );

endmodule

FILE: rtl/u16u8_front.sv
// Front end: accepts UTF-16 units, tracks a pending high surrogate, emits commands.
// Depends on u16u8_pkg and u16u8_in_if.
module u16u8_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    u16u8_in_if.sink           i_in,
    output logic               o_cmd_valid,
    output u16u8_pkg::t_cmd    o_cmd,
    input  logic               i_cmd_ready
);

    logic       r_pend;
    logic [9:0] r_hbits;
    logic       n_pend;
    logic [9:0] n_hbits;
    logic       is_hi;
    logic       is_lo;
    logic       last;
    logic       push;
    logic       accept;
    u16u8_pkg::t_cmd cmd;

    assign is_hi = i_in.code_unit[15:10] == u16u8_pkg::HI_TAG;
    assign is_lo = i_in.code_unit[15:10] == u16u8_pkg::LO_TAG;
    assign last  = i_in.buffer_end;

    always_comb begin
        cmd     = '0;
        n_pend  = 1'b0;
        n_hbits = '0;
        if (r_pend && is_lo) begin
            cmd.has_cp = 1'b1;
            cmd.cp     = u16u8_pkg::CP_SUPP + {1'b0, r_hbits, i_in.code_unit[9:0]};
            cmd.term   = last;
        end else begin
            // a broken pair flushes U+FFFD, then the unit goes through as usual
            cmd.pre = r_pend;
            if (i_in.code_unit == '0) begin
                cmd.term = 1'b1;
            end else if (is_hi) begin
                if (last) begin
                    cmd.has_cp = 1'b1;
                    cmd.cp     = u16u8_pkg::CP_REPL;
                    cmd.term   = 1'b1;
                end else begin
                    n_pend  = 1'b1;
                    n_hbits = i_in.code_unit[9:0];
                end
            end else if (is_lo) begin
                cmd.has_cp = 1'b1;
                cmd.cp     = u16u8_pkg::CP_REPL;
                cmd.term   = last;
            end else begin
                cmd.has_cp = 1'b1;
                cmd.cp     = {5'b00000, i_in.code_unit};
                cmd.term   = last;
            end
        end
    end

    assign push        = cmd.pre | cmd.has_cp | cmd.term;
    assign i_in.ready  = i_cmd_ready;
    assign accept      = i_in.valid & i_cmd_ready;
    assign o_cmd_valid = i_in.valid & push;
    assign o_cmd       = cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend  <= 1'b0;
            r_hbits <= '0;
        end else if (accept) begin
            r_pend  <= n_pend;
            r_hbits <= n_hbits;
        end
    end

endmodule

FILE: rtl/u16u8_queue.sv
// Small command queue between the front end and the byte emitter.
// Depends on u16u8_pkg.
module u16u8_queue #(
    parameter int DEPTH = 2
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  u16u8_pkg::t_cmd    i_data,
    output logic               o_ready,
    output logic               o_valid,
    output u16u8_pkg::t_cmd    o_data,
    input  logic               i_pop
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    u16u8_pkg::t_cmd r_mem [DEPTH];
    logic [PW-1:0]   r_wp;
    logic [PW-1:0]   r_rp;
    logic [CW-1:0]   r_cnt;
    logic            wr;
    logic            rd;

    assign o_ready = r_cnt != CNT_FULL;
    assign o_valid = r_cnt != '0;
    assign o_data  = r_mem[r_rp];
    assign wr      = i_push & o_ready;
    assign rd      = i_pop & o_valid;

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) begin
                r_wp <= (r_wp == PTR_LAST) ? '0 : r_wp + 1'b1;
            end
            if (rd) begin
                r_rp <= (r_rp == PTR_LAST) ? '0 : r_rp + 1'b1;
            end
            if (wr && !rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (rd && !wr) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

FILE: rtl/u16u8_back.sv
// Byte emitter: walks commands into an output register, one byte per unstalled cycle.
// Depends on u16u8_pkg and u16u8_out_if.
module u16u8_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cmd_valid,
    input  u16u8_pkg::t_cmd    i_cmd,
    output logic               o_cmd_pop,
    u16u8_out_if.source        o_out
);

    logic                r_act;
    u16u8_pkg::t_cmd     r_cmd;
    u16u8_pkg::t_phase   r_ph;
    logic [1:0]          r_idx;
    logic                r_ov;
    logic [7:0]          r_byte;
    logic                r_done;

    logic                can_load;
    logic                emit;
    logic                ph_end;
    logic                cmd_end;
    logic                has_next;
    u16u8_pkg::t_phase   nxt_ph;
    logic [7:0]          byte_val;
    logic                done_val;

    assign can_load = !r_ov || o_out.ready;
    assign emit     = r_act && can_load;

    always_comb begin
        byte_val = '0;
        done_val = 1'b0;
        ph_end   = 1'b1;
        has_next = 1'b0;
        nxt_ph   = u16u8_pkg::PH_TERM;
        case (r_ph)
            u16u8_pkg::PH_PRE: begin
                byte_val = u16u8_pkg::utf8_byte(u16u8_pkg::CP_REPL, r_idx);
                ph_end   = r_idx == 2'd2;
                has_next = r_cmd.has_cp | r_cmd.term;
                nxt_ph   = r_cmd.has_cp ? u16u8_pkg::PH_CP : u16u8_pkg::PH_TERM;
            end
            u16u8_pkg::PH_CP: begin
                byte_val = u16u8_pkg::utf8_byte(r_cmd.cp, r_idx);
                ph_end   = r_idx == u16u8_pkg::utf8_last(r_cmd.cp);
                has_next = r_cmd.term;
            end
            u16u8_pkg::PH_TERM: begin
                done_val = 1'b1;
            end
            default: begin
                done_val = 1'b1;
            end
        endcase
    end

    assign cmd_end   = ph_end && !has_next;
    // refill in the cycle the last byte leaves, so back-to-back commands do not bubble
    assign o_cmd_pop = i_cmd_valid && (!r_act || (emit && cmd_end));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= 1'b0;
            r_ph  <= u16u8_pkg::PH_TERM;
            r_idx <= '0;
        end else if (o_cmd_pop) begin
            r_act <= 1'b1;
            r_ph  <= u16u8_pkg::first_phase(i_cmd);
            r_idx <= '0;
        end else if (emit) begin
            if (!ph_end) begin
                r_idx <= r_idx + 1'b1;
            end else if (has_next) begin
                r_ph  <= nxt_ph;
                r_idx <= '0;
            end else begin
                r_act <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_cmd <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (emit) begin
            r_ov <= 1'b1;
        end else if (o_out.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_byte <= byte_val;
            r_done <= done_val;
        end
    end

    assign o_out.valid       = r_ov;
    assign o_out.out_byte    = r_byte;
    assign o_out.string_done = r_done;

endmodule

FILE: sim/utf8_byte_checker.sv
// Checker for the UTF-16LE to UTF-8 transcoder: watches both channels and predicts the bytes.
// Compares each output transfer with the oldest predicted byte.
// Depends on u16u8_ifc (channel interfaces) only.
module utf8_byte_checker (
    input  logic    i_clk,
    input  logic    i_rst_n,
    u16u8_in_if     i_in,
    u16u8_out_if    i_out,
    output int      o_errors,
    output int      o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [5:0]  HIGH_SURR_TAG  = 6'b110110;
    localparam logic [5:0]  LOW_SURR_TAG   = 6'b110111;
    localparam logic [20:0] REPLACEMENT_CP = 21'h00FFFD;
    localparam logic [20:0] SUPP_BASE      = 21'h010000;

    typedef struct packed {
        logic [7:0] octet;
        logic       done;
    } utf8_out_t;

    utf8_out_t   expected_bytes [$];
    logic        hi_waiting;
    logic [9:0]  hi_payload;
    int          err_count;

    function automatic void push_octet(input logic [7:0] octet, input logic done);
        utf8_out_t b;
        b.octet = octet;
        b.done  = done;
        expected_bytes.push_back(b);
    endfunction

    function automatic void push_code_point(input logic [20:0] cp);
        if (cp < 21'h80) begin
            push_octet({1'b0, cp[6:0]}, 1'b0);
        end else if (cp < 21'h800) begin
            push_octet({3'b110, cp[10:6]}, 1'b0);
            push_octet({2'b10, cp[5:0]}, 1'b0);
        end else if (cp < 21'h10000) begin
            push_octet({4'b1110, cp[15:12]}, 1'b0);
            push_octet({2'b10, cp[11:6]}, 1'b0);
            push_octet({2'b10, cp[5:0]}, 1'b0);
        end else begin
            push_octet({5'b11110, cp[20:18]}, 1'b0);
            push_octet({2'b10, cp[17:12]}, 1'b0);
            push_octet({2'b10, cp[11:6]}, 1'b0);
            push_octet({2'b10, cp[5:0]}, 1'b0);
        end
    endfunction

    // Queues the bytes that one accepted code unit produces and updates the surrogate state.
    function automatic void transcode_unit(input logic [15:0] unit, input logic at_end);
        logic is_high;
        logic is_low;
        is_high = (unit[15:10] == HIGH_SURR_TAG);
        is_low  = (unit[15:10] == LOW_SURR_TAG);
        if (hi_waiting) begin
            hi_waiting = 1'b0;
            if (is_low) begin
                push_code_point(SUPP_BASE + {1'b0, hi_payload, unit[9:0]});
                hi_payload = '0;
                if (at_end) begin
                    push_octet(8'h00, 1'b1);
                end
                return;
            end
            hi_payload = '0;
            push_code_point(REPLACEMENT_CP);
        end
        if (unit == 16'h0000) begin
            push_octet(8'h00, 1'b1);
            return;
        end
        if (is_high) begin
            if (!at_end) begin
                hi_waiting = 1'b1;
                hi_payload = unit[9:0];
                return;
            end
            push_code_point(REPLACEMENT_CP);
        end else if (is_low) begin
            push_code_point(REPLACEMENT_CP);
        end else begin
            push_code_point({5'b00000, unit});
        end
        if (at_end) begin
            push_octet(8'h00, 1'b1);
        end
    endfunction

    initial begin
        err_count = 0;
        hi_waiting = 1'b0;
        hi_payload = '0;
        o_errors <= 0;
        o_pending <= 0;
    end

    always @(posedge i_clk) begin
        utf8_out_t want;
        if (!i_rst_n) begin
            hi_waiting = 1'b0;
            hi_payload = '0;
            expected_bytes.delete();
        end else begin
            if (i_in.valid && i_in.ready) begin
                transcode_unit(i_in.code_unit, i_in.buffer_end);
            end
            if (i_out.valid && i_out.ready) begin
                if (expected_bytes.size() == 0) begin
                    $error("out_byte: no byte expected, got %02h (string_done %0b)",
                           i_out.out_byte, i_out.string_done);
                    err_count++;
                end else begin
                    want = expected_bytes.pop_front();
                    if (i_out.out_byte !== want.octet) begin
                        $error("out_byte mismatch: expected %02h, actual %02h",
                               want.octet, i_out.out_byte);
                        err_count++;
                    end
                    if (i_out.string_done !== want.done) begin
                        $error("string_done mismatch: expected %0b, actual %0b",
                               want.done, i_out.string_done);
                        err_count++;
                    end
                end
            end
        end
        o_errors  <= err_count;
        o_pending <= expected_bytes.size();
    end

endmodule

FILE: sim/utf16le_to_utf8_transcoder_top_tb.sv
// Testbench top for the UTF-16LE to UTF-8 transcoder: clock, reset, unit stimulus, receiver stalls.
// Depends on u16u8_ifc, utf16le_to_utf8_transcoder_top and utf8_byte_checker.
module utf16le_to_utf8_transcoder_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_UNITS = 100;
    localparam int LONG_HOLD    = 150;
    localparam int DRAIN_CYCLES = 30;
    localparam int CYCLE_LIMIT  = 200000;

    logic clk = 1'b0;
    logic rst_n;
    int   byte_errors;
    int   bytes_owed;
    int   burst_left;
    int   units_sent;
    int   cycles;
    bit   long_hold_due;
    bit   long_hold_done;

    u16u8_in_if  in_ch ();
    u16u8_out_if out_ch ();

    utf16le_to_utf8_transcoder_top dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    utf8_byte_checker byte_check (
        .i_clk     (clk),
        .i_rst_n   (rst_n),
        .i_in      (in_ch),
        .i_out     (out_ch),
        .o_errors  (byte_errors),
        .o_pending (bytes_owed)
    );

    always #6 clk = ~clk;

    // Offers one unit; returns at the edge where the transfer happens.
    task automatic offer(input logic [15:0] unit, input logic at_end);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 8);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_ch.valid      <= 1'b1;
        in_ch.code_unit  <= unit;
        in_ch.buffer_end <= at_end;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        units_sent++;
    endtask

    function automatic logic [15:0] rand_bmp();
        logic [15:0] u;
        case ($urandom_range(0, 3))
            0: u = 16'($urandom_range(16'h0001, 16'h007F));
            1: u = 16'($urandom_range(16'h0080, 16'h07FF));
            2: u = 16'($urandom_range(16'h0800, 16'hD7FF));
            default: u = 16'($urandom_range(16'hE000, 16'hFFFF));
        endcase
        return u;
    endfunction

    function automatic logic [15:0] rand_high();
        return 16'hD800 | 16'($urandom_range(0, 1023));
    endfunction

    function automatic logic [15:0] rand_low();
        return 16'hDC00 | 16'($urandom_range(0, 1023));
    endfunction

    function automatic logic rare_end();
        return ($urandom_range(0, 15) == 0);
    endfunction

    // Receiver: stall patterns of its own, plus one long hold-off on request.
    initial begin
        int   stretch;
        int   period;
        logic [7:0] mask;
        forever begin
            if (long_hold_due && !long_hold_done) begin
                long_hold_done = 1'b1;
                out_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end else begin
                stretch = $urandom_range(10, 48);
                case ($urandom_range(0, 3))
                    0: begin
                        repeat (stretch) begin
                            out_ch.ready <= 1'b1;
                            @(posedge clk);
                        end
                    end
                    1: begin
                        mask = 8'($urandom());
                        repeat (stretch) begin
                            out_ch.ready <= mask[0];
                            mask = {mask[0], mask[7:1]};
                            @(posedge clk);
                        end
                    end
                    2: begin
                        repeat (stretch) begin
                            out_ch.ready <= ($urandom_range(0, 3) != 0);
                            @(posedge clk);
                        end
                    end
                    default: begin
                        period = $urandom_range(2, 6);
                        for (int i = 0; i < stretch; i++) begin
                            out_ch.ready <= ((i % period) == 0);
                            @(posedge clk);
                        end
                    end
                endcase
            end
        end
    end

    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        logic [15:0] hi;
        burst_left = 0;
        units_sent = 0;
        long_hold_due = 1'b0;
        long_hold_done = 1'b0;
        rst_n <= 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.code_unit <= '0;
        in_ch.buffer_end <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: encoding boundaries and every surrogate corner.
        offer(16'h0041, 1'b0);
        offer(16'h007F, 1'b0);
        offer(16'h0080, 1'b0);
        offer(16'h07FF, 1'b0);
        offer(16'h0800, 1'b0);
        offer(16'hFFFF, 1'b0);
        offer(16'h0000, 1'b0);              // zero unit ends the string
        offer(16'hD800, 1'b0);              // lowest pair
        offer(16'hDC00, 1'b0);
        offer(16'hDBFF, 1'b0);              // highest pair, last unit of buffer
        offer(16'hDFFF, 1'b1);
        offer(16'hDC00, 1'b0);              // lone low
        offer(16'hD800, 1'b0);              // broken pair
        offer(16'h0041, 1'b0);
        offer(16'hDBFF, 1'b1);              // high at buffer end
        offer(16'hD800, 1'b0);              // pending high flushed by zero
        offer(16'h0000, 1'b1);
        offer(16'hD800, 1'b0);              // longest case: FFFD, FFFD, NUL
        offer(16'hDBFF, 1'b1);
        offer(16'hFFFD, 1'b0);
        offer(16'hE000, 1'b1);
        offer(16'hDFFF, 1'b1);              // lone low at buffer end
        offer(16'h0001, 1'b0);

        units_sent = 0;
        while (units_sent < RANDOM_UNITS) begin
            if (units_sent >= 40) begin
                long_hold_due = 1'b1;
            end
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5, 6, 7, 8, 9: begin
                    offer(rand_bmp(), rare_end());
                end
                10, 11, 12, 13: begin
                    offer(rand_high(), 1'b0);
                    offer(rand_low(), rare_end());
                end
                14: offer(16'h0000, 1'($urandom_range(0, 1)));
                15: offer(rand_low(), rare_end());
                16: begin
                    offer(rand_high(), 1'b0);
                    offer(rand_bmp(), rare_end());
                end
                17: offer(rand_high(), 1'b1);
                18: begin
                    hi = rand_high();
                    offer(rand_high(), 1'b0);
                    offer(hi, 1'b0);
                    offer(rand_low(), rare_end());
                end
                default: begin
                    offer(rand_high(), 1'b0);
                    offer(16'h0000, 1'($urandom_range(0, 1)));
                end
            endcase
        end
        in_ch.valid <= 1'b0;

        // Let the checker see the last transfer before polling its count.
        @(posedge clk);
        while (bytes_owed != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (byte_errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/u16u8_pkg.sv
rtl/u16u8_ifc.sv
rtl/u16u8_front.sv
rtl/u16u8_queue.sv
rtl/u16u8_back.sv
rtl/utf16le_to_utf8_transcoder_top.sv
sim/utf8_byte_checker.sv
sim/utf16le_to_utf8_transcoder_top_tb.sv
